// File: hdl/kruskal_mst_cost_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the spanning-tree cost core
// Shared property forms; each use starts on a line of its own.
// ---------------------------------------------------------------------------
`ifndef KRUSKAL_MST_COST_CORE_DEFINES_SVH
`define KRUSKAL_MST_COST_CORE_DEFINES_SVH

// implication checked every cycle out of reset
`define KMC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define KMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/kmc_pkg.sv
// ---------------------------------------------------------------------------
// kmc_pkg
// Types, widths and state codes of the spanning-tree cost core.
// ---------------------------------------------------------------------------
`default_nettype none
package kmc_pkg;
    localparam int MAX_VERTICES = 64;
    localparam int MAX_EDGES    = 2048;
    localparam int COST_BITS    = 20;
    localparam int VW           = 7;
    localparam int PW           = $clog2(MAX_VERTICES);
    localparam int EW           = $clog2(MAX_EDGES);
    localparam int FW           = EW + 1;
    localparam int ENTRY_W      = 2 * VW + COST_BITS;
    localparam int TOTAL_W      = 26;
    localparam int TAKEN_W      = 6;

    typedef struct packed {
        logic [VW-1:0] vertex_a;
        logic [VW-1:0] vertex_b;
        logic [19:0]   edge_cost;
        logic          last_edge;
    } in_item_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] total_cost;
        logic [TAKEN_W-1:0] edges_taken;
    } out_item_t;

    typedef struct packed {
        logic [VW-1:0]        a;
        logic [VW-1:0]        b;
        logic [COST_BITS-1:0] cost;
    } entry_t;

    typedef enum logic [4:0] {
        ST_LOAD, ST_CLEAR,
        ST_HEAP_NEXT, ST_SIFT_RD, ST_SIFT_WL, ST_SIFT_WR, ST_SIFT_CMP,
        ST_SIFT_SWAP,
        ST_EXT_RD, ST_EXT_WAIT, ST_EXT_SWAP,
        ST_SCAN_RD, ST_SCAN_WAIT, ST_SCAN_CHK,
        ST_FIND_A, ST_FIND_A_CHK, ST_COMP_A, ST_COMP_A_WR,
        ST_FIND_B, ST_FIND_B_CHK, ST_COMP_B, ST_COMP_B_WR,
        ST_JOIN,
        ST_OUT
    } state_t;
endpackage
`default_nettype wire

// File: hdl/kmc_ram.sv
// ---------------------------------------------------------------------------
// kmc_ram
// Single-port RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module kmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// File: hdl/kruskal_mst_cost_core.sv
// ---------------------------------------------------------------------------
// kruskal_mst_cost_core
// Spanning-forest cost core. While ready (stall low) the core takes one edge
// item per cycle and appends it to a 2048-entry edge RAM; edges that arrive
// with the store full are dropped. The item with last_edge set starts a
// build, and input stall stays high until the build is done: clear the
// 64-entry parent RAM, heap-sort the stored edges in place in the
// single-port edge RAM (each sift level reads the node and its two children,
// compares and writes; each extraction swaps root and last item), then
// scan them in cost order with find and path compression over the parent RAM
// (a root read, then one parent hop per step; each compressed node is read,
// then rewritten; then a join). The result item (total cost, edges taken)
// moves into an output register and loading resumes at once; a build that
// finishes while the previous result is still waiting holds until that one
// is taken. The single edge RAM port is the limit on sort time.
// ---------------------------------------------------------------------------
`default_nettype none
`include "kruskal_mst_cost_core_defines.svh"
module kruskal_mst_cost_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [6:0]         cfg_wdata,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire kmc_pkg::in_item_t  in_item,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output kmc_pkg::out_item_t      out_item
);
    import kmc_pkg::*;

    state_t state_reg, state_next;
    logic [6:0]        nv_cfg_reg;
    logic [FW-1:0]     fill_reg, fill_next;
    logic [FW-1:0]     n_reg, n_next;      // heap size
    logic [FW-1:0]     hcnt_reg, hcnt_next; // build index / scan index
    logic [FW-1:0]     i_reg, i_next;      // sift node
    logic [FW-1:0]     big_reg, big_next;
    logic              build_reg, build_next;
    entry_t            ei_reg, ei_next, el_reg, el_next, er_reg, er_next;
    logic              hl_reg, hl_next, hr_reg, hr_next;
    logic [PW:0]       clr_reg, clr_next;
    logic [PW-1:0]     ra_reg, ra_next, rb_reg, rb_next, cur_reg, cur_next;
    logic [PW-1:0]     va_reg, va_next, vb_reg, vb_next;
    logic [TOTAL_W-1:0] tot_reg, tot_next;
    logic [TAKEN_W-1:0] tk_reg, tk_next;
    logic              ov_reg, ov_next;
    out_item_t         res_reg, res_next;

    logic              ram_we;
    logic [EW-1:0]     ram_addr;
    entry_t            ram_wdata, ram_rdata;

    logic              par_we;
    logic [PW-1:0]     par_addr, par_wd, par_rdata;
    logic              accept;
    logic [6:0]        nv_eff;
    logic [TOTAL_W:0]  sum;

    kmc_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_EDGES)) u_edge_ram (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    kmc_ram #(.WIDTH(PW), .DEPTH(MAX_VERTICES)) u_parent_ram (
        .clk  (clk),
        .we   (par_we),
        .addr (par_addr),
        .wdata(par_wd),
        .rdata(par_rdata)
    );

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_LOAD);
    assign out_valid = ov_reg;
    assign out_item  = res_reg;
    assign nv_eff    = (nv_cfg_reg > 7'(MAX_VERTICES)) ? 7'(MAX_VERTICES) : nv_cfg_reg;
    assign sum       = {1'b0, tot_reg} + (TOTAL_W+1)'(ei_reg.cost);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_LOAD;
            nv_cfg_reg <= 7'(MAX_VERTICES);
            fill_reg   <= '0;
            ov_reg     <= 1'b0;
            res_reg    <= '0;
            clr_reg    <= '0;
            build_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                nv_cfg_reg <= cfg_wdata;
            end
            fill_reg  <= fill_next;
            ov_reg    <= ov_next;
            res_reg   <= res_next;
            clr_reg   <= clr_next;
            build_reg <= build_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next; hcnt_reg <= hcnt_next; i_reg <= i_next; big_reg <= big_next;
        ei_reg <= ei_next; el_reg <= el_next; er_reg <= er_next;
        hl_reg <= hl_next; hr_reg <= hr_next;
        ra_reg <= ra_next; rb_reg <= rb_next; cur_reg <= cur_next;
        va_reg <= va_next; vb_reg <= vb_next;
        tot_reg <= tot_next; tk_reg <= tk_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:      if (accept && in_item.last_edge) state_next = ST_CLEAR;
            ST_CLEAR:     if (clr_reg == (PW+1)'(MAX_VERTICES - 1))
                              state_next = ST_HEAP_NEXT;
            ST_HEAP_NEXT: if (hcnt_reg == '0)
                              state_next = (n_reg > FW'(1)) ? ST_EXT_RD : ST_SCAN_RD;
                          else
                              state_next = ST_SIFT_RD;
            ST_SIFT_RD:   state_next = ST_SIFT_WL;
            ST_SIFT_WL:   state_next = ST_SIFT_WR;
            ST_SIFT_WR:   state_next = ST_SIFT_CMP;
            ST_SIFT_CMP:  state_next = ST_SIFT_SWAP;
            ST_SIFT_SWAP: if (big_reg == i_reg)
                              state_next = build_reg ? ST_HEAP_NEXT
                                         : ((n_reg > FW'(1)) ? ST_EXT_RD : ST_SCAN_RD);
                          else
                              state_next = ST_SIFT_RD;
            ST_EXT_RD:    state_next = ST_EXT_WAIT;
            ST_EXT_WAIT:  state_next = ST_EXT_SWAP;
            ST_EXT_SWAP:  state_next = ST_SIFT_RD;
            ST_SCAN_RD:   state_next = (hcnt_reg == fill_reg) ? ST_OUT : ST_SCAN_WAIT;
            ST_SCAN_WAIT: state_next = ST_SCAN_CHK;
            ST_SCAN_CHK:  state_next = ST_FIND_A;
            ST_FIND_A:    state_next = ST_FIND_A_CHK;
            ST_FIND_A_CHK: if (par_rdata == ra_reg) state_next = ST_COMP_A;
            ST_COMP_A:    state_next = (cur_reg == ra_reg) ? ST_FIND_B : ST_COMP_A_WR;
            ST_COMP_A_WR: state_next = ST_COMP_A;
            ST_FIND_B:    state_next = ST_FIND_B_CHK;
            ST_FIND_B_CHK: if (par_rdata == rb_reg) state_next = ST_COMP_B;
            ST_COMP_B:    state_next = (cur_reg == rb_reg) ? ST_JOIN : ST_COMP_B_WR;
            ST_COMP_B_WR: state_next = ST_COMP_B;
            ST_JOIN:      state_next = ST_SCAN_RD;
            ST_OUT:       if (!ov_reg || !out_stall) state_next = ST_LOAD;
            default:      state_next = ST_LOAD;
        endcase
        if (state_reg == ST_SCAN_CHK)
        begin
            // drop edges with an endpoint outside 1..vertex count
            if (ram_rdata.a == '0 || ram_rdata.b == '0 || ram_rdata.a > nv_eff
                || ram_rdata.b > nv_eff)
            begin
                state_next = ST_SCAN_RD;
            end
        end
    end

    // datapath and outputs
    always_comb
    begin
        fill_next = fill_reg; n_next = n_reg; hcnt_next = hcnt_reg;
        i_next = i_reg; big_next = big_reg; build_next = build_reg;
        ei_next = ei_reg; el_next = el_reg; er_next = er_reg;
        hl_next = hl_reg; hr_next = hr_reg;
        ra_next = ra_reg; rb_next = rb_reg; cur_next = cur_reg;
        va_next = va_reg; vb_next = vb_reg;
        tot_next = tot_reg; tk_next = tk_reg; clr_next = clr_reg;
        ov_next = ov_reg && out_stall;
        res_next = res_reg;
        ram_we = 1'b0; ram_addr = i_reg[EW-1:0]; ram_wdata = ei_reg;
        par_we = 1'b0; par_addr = '0; par_wd = '0;
        case (state_reg)
            ST_LOAD:
            begin
                ram_addr  = fill_reg[EW-1:0];
                ram_wdata = '{a: in_item.vertex_a, b: in_item.vertex_b,
                              cost: in_item.edge_cost[COST_BITS-1:0]};
                if (accept && fill_reg < FW'(MAX_EDGES))
                begin
                    ram_we    = 1'b1;
                    fill_next = fill_reg + FW'(1);
                end
                clr_next = '0;
            end
            ST_CLEAR:
            begin
                par_we    = 1'b1;
                par_addr  = clr_reg[PW-1:0];
                par_wd    = clr_reg[PW-1:0];
                clr_next  = clr_reg + (PW+1)'(1);
                n_next    = fill_reg;
                hcnt_next = fill_reg >> 1;
                build_next = 1'b1;
            end
            ST_HEAP_NEXT:
            begin
                if (hcnt_reg == '0)
                begin
                    build_next = 1'b0;
                    hcnt_next  = '0;
                end
                else
                begin
                    hcnt_next = hcnt_reg - FW'(1);
                    i_next    = hcnt_reg - FW'(1);
                end
            end
            ST_SIFT_RD:
            begin
                ram_addr = i_reg[EW-1:0];
            end
            ST_SIFT_WL:
            begin
                // load the moving item only on the first level of a heap-build sift;
                // deeper levels and extraction sifts carry it in ei
                if (build_reg && i_reg == hcnt_reg)
                    ei_next = ram_rdata;
                ram_addr = EW'({i_reg, 1'b1});
                hl_next  = ({i_reg, 1'b1} < {1'b0, n_reg});
            end
            ST_SIFT_WR:
            begin
                el_next  = ram_rdata;
                ram_addr = EW'({i_reg, 1'b0} + (FW+1)'(2));
                hr_next  = (({i_reg, 1'b0} + (FW+1)'(2)) < {1'b0, n_reg});
            end
            ST_SIFT_CMP:
            begin
                er_next  = ram_rdata;
                big_next = i_reg;
                if (hl_reg && el_reg.cost > ei_reg.cost)
                begin
                    big_next = FW'({i_reg, 1'b1});
                    if (hr_reg && ram_rdata.cost > el_reg.cost)
                        big_next = FW'({i_reg, 1'b0} + (FW+1)'(2));
                end
                else if (hr_reg && ram_rdata.cost > ei_reg.cost)
                begin
                    big_next = FW'({i_reg, 1'b0} + (FW+1)'(2));
                end
            end
            ST_SIFT_SWAP:
            begin
                // write child into node i; the moving item is written where the sift stops
                if (big_reg != i_reg)
                begin
                    ram_we    = 1'b1;
                    ram_addr  = i_reg[EW-1:0];
                    ram_wdata = (big_reg[0]) ? el_reg : er_reg;
                    i_next    = big_reg;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_addr  = i_reg[EW-1:0];
                    ram_wdata = ei_reg;
                end
            end
            ST_EXT_RD:
            begin
                ram_addr = EW'(n_reg - FW'(1));
                ei_next  = ei_reg;
            end
            ST_EXT_WAIT:
            begin
                el_next  = ram_rdata;          // last heap item
                ram_addr = '0;
            end
            ST_EXT_SWAP:
            begin
                // root to end, last item to root; shrink heap and sift
                ram_we    = 1'b1;
                ram_addr  = EW'(n_reg - FW'(1));
                ram_wdata = ram_rdata;
                n_next    = n_reg - FW'(1);
                i_next    = '0;
                hcnt_next = '0;
                ei_next   = el_reg;
            end
            ST_SCAN_RD:
            begin
                ram_addr = hcnt_reg[EW-1:0];
                if (hcnt_reg == fill_reg)
                begin
                    fill_next = '0;
                end
            end
            ST_SCAN_WAIT:
            begin
                // hold the address so the read data is still this edge next cycle
                ram_addr  = hcnt_reg[EW-1:0];
                hcnt_next = hcnt_reg + FW'(1);
            end
            ST_SCAN_CHK:
            begin
                ei_next = ram_rdata;
                va_next = PW'(ram_rdata.a - 7'd1);
                vb_next = PW'(ram_rdata.b - 7'd1);
                ra_next = PW'(ram_rdata.a - 7'd1);
                rb_next = PW'(ram_rdata.b - 7'd1);
                cur_next = PW'(ram_rdata.a - 7'd1);
            end
            ST_FIND_A:
            begin
                par_addr = ra_reg;
            end
            ST_FIND_A_CHK:
            begin
                // follow one parent per cycle; read the next one right away
                if (par_rdata != ra_reg)
                begin
                    ra_next  = par_rdata;
                    par_addr = par_rdata;
                end
                cur_next = va_reg;
            end
            ST_COMP_A:
            begin
                if (cur_reg != ra_reg)
                    par_addr = cur_reg;
                else
                    cur_next = vb_reg;
            end
            ST_COMP_A_WR:
            begin
                par_we = 1'b1; par_addr = cur_reg; par_wd = ra_reg;
                cur_next = par_rdata;
            end
            ST_FIND_B:
            begin
                par_addr = rb_reg;
            end
            ST_FIND_B_CHK:
            begin
                if (par_rdata != rb_reg)
                begin
                    rb_next  = par_rdata;
                    par_addr = par_rdata;
                end
                cur_next = vb_reg;
            end
            ST_COMP_B:
            begin
                if (cur_reg != rb_reg)
                    par_addr = cur_reg;
            end
            ST_COMP_B_WR:
            begin
                par_we = 1'b1; par_addr = cur_reg; par_wd = rb_reg;
                cur_next = par_rdata;
            end
            ST_JOIN:
            begin
                if (ra_reg != rb_reg)
                begin
                    par_we   = 1'b1; par_addr = rb_reg; par_wd = ra_reg;
                    tot_next = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
                    if (tk_reg != '1) tk_next = tk_reg + TAKEN_W'(1);
                end
            end
            ST_OUT:
            begin
                // hand the result to the output register once it is free
                if (!ov_reg || !out_stall)
                begin
                    ov_next  = 1'b1;
                    res_next = '{total_cost: tot_reg, edges_taken: tk_reg};
                end
            end
            default: ;
        endcase
        if (state_reg == ST_CLEAR)
        begin
            tot_next = '0;
            tk_next  = '0;
        end
        if (state_reg == ST_HEAP_NEXT && hcnt_reg == '0 && n_reg <= FW'(1))
        begin
            hcnt_next = '0;
        end
    end

    `KMC_ASSERT_IMP(a_stall_busy, clk, rst_n, state_reg != ST_LOAD, in_stall)
    `KMC_ASSERT_IMP(a_fill_cap, clk, rst_n, 1'b1, fill_reg <= FW'(MAX_EDGES))
    `KMC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(out_item))
    `KMC_ASSERT_NEXT(a_done_empty, clk, rst_n, state_reg == ST_OUT,
        fill_reg == '0 && out_valid)
endmodule
`default_nettype wire
